>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> hdl/alf_pkg.sv
// ----------------------------------------------------------------------------
// alf_pkg
// Types and constants shared by the antialiased line framebuffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package alf_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int COORD_W = 11;
    localparam int CFG_W   = 7;
    localparam int COLOR_W = 32;
    localparam int REQ_W   = 2;
    localparam int CNT_W   = COORD_W;
    localparam int DM_W    = COORD_W + 1;
    localparam int TW      = COORD_W + 1;
    localparam int PIX_W   = COORD_W + 3;
    localparam int POS_W   = PIX_W + FRAC_BITS;
    localparam int COV_W   = FRAC_BITS + 1;
    localparam int SLOPE_W = FRAC_BITS + 2;
    localparam int DVD_W   = COORD_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LINE  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       steep;
        logic                       single;
        logic signed [COORD_W-1:0]  start;
        logic [CNT_W-1:0]           count;
        logic signed [COORD_W-1:0]  minor;
        logic signed [DM_W-1:0]     dmin;
        logic [COLOR_W-1:0]         color;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic             we;
        logic [1:0]       addr;
        logic [CFG_W-1:0] wdata;
    } cfg_wr_t;

endpackage

`default_nettype wire

>>> hdl/antialiased_line_framebuffer.sv
// ----------------------------------------------------------------------------
// antialiased_line_framebuffer
// ARGB framebuffer with pixel writes, pixel reads and antialiased line draws.
// ----------------------------------------------------------------------------
// Request items arrive on the s_ channel and each produces exactly one result
// item on the m_ channel: the pixel for a read (all ones when outside the
// frame), zero otherwise, with an out-of-bounds flag for pixel accesses.
// Items are handled one at a time by the drawing engine; a four-entry command
// queue lets the front end keep accepting while the engine works.
// A pixel write is done in the address state; a pixel read also passes through
// the read-data state. Axis-aligned line: each pixel is a read-modify-write of
// the store (read, multiply, blend). Sloped line: the slope divider runs
// first (one quotient bit per cycle), then each major-axis step blends its
// two pixels. After reset the engine clears the 4096-word store, one word
// per cycle; s_tready stays low until the clear is done, while register
// writes are taken.
// When m_tready is low the finished result is held in the output register
// and no further command starts until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_framebuffer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_addr,
    input  wire logic [alf_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // req_type[1:0], x0[12:2], y0[23:13], x1[34:24], y1[45:35],
    // pixel_color[77:46], zero fill up to bit 79
    input  wire logic [alf_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_data[31:0], out_of_bounds[32], zero fill up to bit 39
    output logic [alf_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import alf_pkg::*;

    cmd_push_t          push;
    cmd_t               head;
    queue_stat_t        qstat;
    cfg_wr_t            cfg;
    logic               pop;
    logic               engine_ready;
    logic [COLOR_W-1:0] read_data;
    logic               out_of_bounds;

    assign cfg.we    = cfg_we;
    assign cfg.addr  = cfg_addr;
    assign cfg.wdata = cfg_wdata;

    alf_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .engine_ready (engine_ready),
        .qstat        (qstat),
        .push         (push)
    );

    alf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (qstat)
    );

    alf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .engine_ready (engine_ready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (read_data),
        .out_oob      (out_of_bounds)
    );

    assign m_tdata = {{(OUT_TDATA_W-COLOR_W-1){1'b0}}, out_of_bounds, read_data};

endmodule

`default_nettype wire

>>> hdl/alf_queue.sv
// ----------------------------------------------------------------------------
// alf_queue
// Short command queue between the request front end and the drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  alf_pkg::cmd_push_t       push,
    input  wire logic                pop,
    output alf_pkg::cmd_t            head,
    output alf_pkg::queue_stat_t     stat
);
    import alf_pkg::*;

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head       = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/alf_front.sv
// ----------------------------------------------------------------------------
// alf_front
// Accepts request items and classifies them into engine commands.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_front (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [alf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            engine_ready,
    input  alf_pkg::queue_stat_t                 qstat,
    output alf_pkg::cmd_push_t                   push
);
    import alf_pkg::*;

    logic [REQ_W-1:0]          req;
    logic signed [COORD_W-1:0] x0, y0, x1, y1;
    logic [COLOR_W-1:0]        color;
    logic signed [DM_W-1:0]    dx, dy, adx, ady;
    cmd_t                      cmd;

    assign req   = s_tdata[1:0];
    assign x0    = s_tdata[12:2];
    assign y0    = s_tdata[23:13];
    assign x1    = s_tdata[34:24];
    assign y1    = s_tdata[45:35];
    assign color = s_tdata[77:46];

    assign dx  = DM_W'(x1) - DM_W'(x0);
    assign dy  = DM_W'(y1) - DM_W'(y0);
    assign adx = dx[DM_W-1] ? -dx : dx;
    assign ady = dy[DM_W-1] ? -dy : dy;

    // The walk always runs upward along the major axis; the minor delta
    // is taken from the chosen start point.
    always_comb begin
        cmd        = '0;
        cmd.color  = color;
        cmd.start  = x0;
        cmd.minor  = y0;
        unique case (req)
            REQ_WRITE: cmd.kind = CMD_WRITE;
            REQ_READ:  cmd.kind = CMD_READ;
            REQ_LINE: begin
                cmd.kind = CMD_LINE;
                if (dx == '0) begin
                    cmd.steep  = 1'b1;
                    cmd.single = 1'b1;
                    cmd.start  = (y0 < y1) ? y0 : y1;
                    cmd.minor  = x0;
                    cmd.count  = ady[CNT_W-1:0];
                end else if (dy == '0) begin
                    cmd.single = 1'b1;
                    cmd.start  = (x0 < x1) ? x0 : x1;
                    cmd.minor  = y0;
                    cmd.count  = adx[CNT_W-1:0];
                end else if (adx > ady) begin
                    cmd.count = adx[CNT_W-1:0];
                    if (x1 < x0) begin
                        cmd.start = x1;
                        cmd.minor = y1;
                        cmd.dmin  = -dy;
                    end else begin
                        cmd.start = x0;
                        cmd.minor = y0;
                        cmd.dmin  = dy;
                    end
                end else begin
                    cmd.steep = 1'b1;
                    cmd.count = ady[CNT_W-1:0];
                    if (y1 < y0) begin
                        cmd.start = y1;
                        cmd.minor = x1;
                        cmd.dmin  = -dx;
                    end else begin
                        cmd.start = y0;
                        cmd.minor = x0;
                        cmd.dmin  = dx;
                    end
                end
            end
            REQ_NONE:  cmd.kind = CMD_NOP;
            default:   cmd.kind = CMD_NOP;
        endcase
    end

    assign s_tready   = engine_ready && !qstat.full;
    assign push.valid = s_tvalid && s_tready;
    assign push.cmd   = cmd;

endmodule

`default_nettype wire

>>> hdl/alf_back.sv
// ----------------------------------------------------------------------------
// alf_back
// Drawing engine: owns the frame store, serves pixel writes and reads, runs
// the slope divider, walks lines and blends pixels by read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  alf_pkg::cfg_wr_t                   cfg,
    input  alf_pkg::cmd_t                      head,
    input  alf_pkg::queue_stat_t               qstat,
    output logic                               pop,
    output logic                               engine_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [alf_pkg::COLOR_W-1:0]        out_data,
    output logic                               out_oob
);
    import alf_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_ADDR  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_BLEND = 8'b0010_0000,
        ST_RDATA = 8'b0100_0000,
        ST_SPARE = 8'b1000_0000
    } state_t;

    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

    logic [COLOR_W-1:0]        mem [STORE_DEPTH];
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [COLOR_W-1:0]        mem_wdata;
    logic [COLOR_W-1:0]        rdata_reg;

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         clr_cnt_reg, clr_cnt_next;
    cmd_t                      cmd_reg, cmd_next;
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic signed [TW-1:0]      t_reg, t_next;
    logic [CNT_W-1:0]          left_reg, left_next;
    logic                      phase_reg, phase_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [DVD_W-1:0]          quo_reg, quo_next;
    logic [DVD_W-1:0]          dvd_reg, dvd_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic                      inside_reg, inside_next;
    logic [7:0]                as_reg, as_next;
    logic [15:0]               tp_reg [3];
    logic [15:0]               bp_reg [3];
    logic                      out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]        out_data_reg, out_data_next;
    logic                      out_oob_reg, out_oob_next;
    logic [CFG_W-1:0]          width_reg, height_reg;

    logic signed [PIX_W-1:0]   fl, mc, tx, px, py;
    logic [FRAC_BITS-1:0]      frac;
    logic [COV_W-1:0]          cov;
    logic [CFG_W-1:0]          w_eff, h_eff;
    logic                      pix_in;
    logic [2*ADDR_W-1:0]       row_full;
    logic [ADDR_W-1:0]         idx;
    logic [8+COV_W-1:0]        acov;
    logic [CNT_W:0]            rem_sh;
    logic                      div_ge;
    logic [SLOPE_W-1:0]        quo_mag;
    logic [COORD_W-1:0]        dabs;
    logic signed [DM_W-1:0]    dm_neg;
    logic [COLOR_W-1:0]        blend_res;
    logic [16:0]               ch_sum [3];

    assign engine_ready = (state_reg != ST_CLEAR);
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign out_oob      = out_oob_reg;

    assign w_eff = (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;

    // Pixel address for the current walk position; floor of the minor position
    // is its integer part taken with the sign.
    assign fl   = pos_reg[POS_W-1:FRAC_BITS];
    assign frac = pos_reg[FRAC_BITS-1:0];
    assign mc   = fl + PIX_W'(phase_reg);
    assign tx   = PIX_W'(t_reg);
    assign px   = cmd_reg.steep ? mc : tx;
    assign py   = cmd_reg.steep ? tx : mc;
    assign cov  = phase_reg ? COV_W'(frac) : (COV_W'(1) << FRAC_BITS) - COV_W'(frac);

    assign pix_in = !px[PIX_W-1] && !py[PIX_W-1]
                 && (px < $signed({{(PIX_W-CFG_W){1'b0}}, w_eff}))
                 && (py < $signed({{(PIX_W-CFG_W){1'b0}}, h_eff}));
    assign row_full = py[ADDR_W-1:0] * ADDR_W'(w_eff);
    assign idx      = row_full[ADDR_W-1:0] + px[ADDR_W-1:0];
    assign acov     = cmd_reg.color[31:24] * cov;

    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge  = rem_sh >= {1'b0, cmd_reg.count};
    assign quo_mag = {1'b0, quo_reg[SLOPE_W-2:0]};
    assign dm_neg  = -head.dmin;
    assign dabs    = head.dmin[DM_W-1] ? dm_neg[COORD_W-1:0] : head.dmin[COORD_W-1:0];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ch_sum[c] = 17'(tp_reg[c]) + 17'(bp_reg[c]);
        end
        blend_res = {8'hFF, div255(ch_sum[2][15:0]), div255(ch_sum[1][15:0]),
                     div255(ch_sum[0][15:0])};
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        t_next         = t_reg;
        left_next      = left_reg;
        phase_next     = phase_reg;
        slope_next     = slope_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvd_next       = dvd_reg;
        div_cnt_next   = div_cnt_reg;
        addr_next      = addr_reg;
        inside_next    = inside_reg;
        as_next        = as_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_oob_next   = out_oob_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx;
        mem_wdata      = cmd_reg.color;
        mem_raddr      = idx;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // A new command starts only once the result register is free.
                if (!qstat.empty && !out_valid_reg) begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    pos_next   = $signed({{(POS_W-FRAC_BITS-COORD_W){head.minor[COORD_W-1]}},
                                          head.minor, {FRAC_BITS{1'b0}}});
                    t_next     = TW'(head.start);
                    left_next  = head.count;
                    phase_next = 1'b0;
                    slope_next = '0;
                    if (head.kind == CMD_NOP) begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_oob_next   = 1'b0;
                    end else if (head.kind == CMD_LINE && !head.single) begin
                        rem_next     = '0;
                        quo_next     = '0;
                        dvd_next     = {dabs, {FRAC_BITS{1'b0}}};
                        div_cnt_next = DIV_CNT_W'(DVD_W);
                        state_next   = ST_DIV;
                    end else begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    slope_next = cmd_reg.dmin[DM_W-1] ? -$signed(quo_mag) : $signed(quo_mag);
                    state_next = ST_ADDR;
                end else begin
                    rem_next     = div_ge ? CNT_W'(rem_sh - {1'b0, cmd_reg.count})
                                          : rem_sh[CNT_W-1:0];
                    quo_next     = {quo_reg[DVD_W-2:0], div_ge};
                    dvd_next     = {dvd_reg[DVD_W-2:0], 1'b0};
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_ADDR: begin
                addr_next   = idx;
                inside_next = pix_in;
                as_next     = acov[FRAC_BITS +: 8];
                unique case (cmd_reg.kind)
                    CMD_WRITE: begin
                        mem_we         = pix_in;
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_oob_next   = !pix_in;
                        state_next     = ST_IDLE;
                    end
                    CMD_READ:  state_next = ST_RDATA;
                    CMD_LINE:  state_next = ST_MUL;
                    CMD_NOP:   state_next = ST_IDLE;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_RDATA: begin
                out_valid_next = 1'b1;
                out_data_next  = inside_reg ? rdata_reg : '1;
                out_oob_next   = !inside_reg;
                state_next     = ST_IDLE;
            end
            ST_MUL: begin
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                mem_we    = inside_reg;
                mem_waddr = addr_reg;
                mem_wdata = blend_res;
                if (!cmd_reg.single && !phase_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_ADDR;
                end else begin
                    phase_next = 1'b0;
                    if (left_reg == '0) begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_oob_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        left_next  = left_reg - 1'b1;
                        t_next     = t_reg + 1'b1;
                        pos_next   = pos_reg + POS_W'(slope_reg);
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_SPARE:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            width_reg     <= CFG_W'(64);
            height_reg    <= CFG_W'(64);
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            if (cfg.we && cfg.addr == CFG_WIDTH) begin
                width_reg <= cfg.wdata;
            end
            if (cfg.we && cfg.addr == CFG_HEIGHT) begin
                height_reg <= cfg.wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        t_reg        <= t_next;
        left_reg     <= left_next;
        slope_reg    <= slope_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvd_reg      <= dvd_next;
        div_cnt_reg  <= div_cnt_next;
        addr_reg     <= addr_next;
        inside_reg   <= inside_next;
        as_reg       <= as_next;
        out_data_reg <= out_data_next;
        out_oob_reg  <= out_oob_next;
        for (int c = 0; c < 3; c++) begin
            tp_reg[c] <= cmd_reg.color[8*c +: 8] * as_reg;
            bp_reg[c] <= rdata_reg[8*c +: 8] * (8'hFF - as_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/alf_checker.sv
// ----------------------------------------------------------------------------
// alf_checker
// Port-level checks on the antialiased line framebuffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module alf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // No result may come out of reset.
    `ASSERT_CLK(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // The store is being cleared after reset, so no item may be taken.
    `ASSERT_CLK(a_busy_after_reset, aclk, !aresetn |=> !s_tready, "ready during store clear")

    // A stalled result holds.
    `ASSERT_RST(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // An out-of-bounds access returns all ones for a read or zero for a write.
    `ASSERT_RST(a_oob_data, aclk, aresetn, m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'hFFFF_FFFF || m_tdata[31:0] == 32'h0, "bad out-of-bounds data")

endmodule

bind antialiased_line_framebuffer alf_checker u_alf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
